/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/lfc_pkg.sv */
`default_nettype none
package lfc_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int PIN_BITS  = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int TAG_W     = 32;
    localparam int TIME_W    = 32;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [PIN_BITS-1:0] t_pin;
    typedef logic [TAG_W-1:0]    t_tag;
    typedef logic [TIME_W-1:0]   t_time;

    // one tag store entry
    typedef struct packed {
        t_tag  tag;
        t_time last_use;
    } t_entry;

    // control from the sequencer to the scan tracker
    typedef struct packed {
        logic start;
        logic rd_vld;
        t_idx slot;
        logic slot_valid;
        logic slot_pinned;
    } t_scan_ctl;

    // outcome of a full scan
    typedef struct packed {
        logic hit;
        t_idx hit_slot;
        logic found;
        t_idx best;
    } t_scan_res;

    // actions
    localparam logic [1:0] ACT_GET        = 2'd0;
    localparam logic [1:0] ACT_UNLOCK     = 2'd1;
    localparam logic [1:0] ACT_UNLOCK_ALL = 2'd2;
    localparam logic [1:0] ACT_PURGE      = 2'd3;

    // status codes
    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_MISS       = 3'd1;
    localparam logic [2:0] ST_ALL_PINNED = 3'd2;
    localparam logic [2:0] ST_DONE       = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd4;

    localparam t_pin PIN_MAX = {PIN_BITS{1'b1}};

    // low three bits of a slot index
    function automatic logic [2:0] idx_to_rs(input t_idx idx);
        logic [IDX_W+2:0] w;
        w = {3'b000, idx};
        return w[2:0];
    endfunction

    // slot field to slot index, valid only when in range
    function automatic t_idx slot_to_idx(input logic [2:0] s);
        logic [IDX_W+2:0] w;
        w = {{IDX_W{1'b0}}, s};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic slot_in_range(input logic [2:0] s);
        return int'(s) < NUM_SLOTS;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lfc_if.sv */
`default_nettype none
// request channel
interface lfc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] frame_number;
    logic [2:0]  slot;

    modport source (output valid, action, frame_number, slot, input ready);
    modport sink   (input valid, action, frame_number, slot, output ready);
endinterface

// response channel
interface lfc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] result_slot;

    modport source (output valid, status, result_slot, input ready);
    modport sink   (input valid, status, result_slot, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lfc_tag_ram.sv */
`default_nettype none
module lfc_tag_ram import lfc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rd_en,
    input  t_idx   i_rd_addr,
    output t_entry o_rd_data,
    input  logic   i_wr_en,
    input  t_idx   i_wr_addr,
    input  t_entry i_wr_data
);

    t_entry r_mem [NUM_SLOTS];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* hw/rtl/lfc_scan.sv */
`default_nettype none
module lfc_scan import lfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_tag      i_frame,
    input  t_time     i_use_cnt,
    input  t_entry    i_entry,
    output t_scan_res o_res
);

    logic  r_hit, n_hit;
    t_idx  r_hit_slot, n_hit_slot;
    logic  r_found, n_found;
    logic  r_found_empty, n_found_empty;
    t_idx  r_best, n_best;
    t_time r_best_age, n_best_age;
    t_time age;

    assign age = i_use_cnt - i_entry.last_use;

    // fold one slot per cycle into the match and victim trackers
    always_comb begin
        n_hit         = r_hit;
        n_hit_slot    = r_hit_slot;
        n_found       = r_found;
        n_found_empty = r_found_empty;
        n_best        = r_best;
        n_best_age    = r_best_age;
        if (i_ctl.start) begin
            n_hit         = 1'b0;
            n_found       = 1'b0;
            n_found_empty = 1'b0;
        end else if (i_ctl.rd_vld) begin
            if (i_ctl.slot_valid && i_entry.tag == i_frame && !r_hit) begin
                n_hit      = 1'b1;
                n_hit_slot = i_ctl.slot;
            end
            if (!i_ctl.slot_pinned) begin
                if (!i_ctl.slot_valid) begin
                    if (!r_found_empty) begin
                        n_found_empty = 1'b1;
                        n_found       = 1'b1;
                        n_best        = i_ctl.slot;
                    end
                end else if (!r_found_empty && (!r_found || age > r_best_age)) begin
                    n_found    = 1'b1;
                    n_best     = i_ctl.slot;
                    n_best_age = age;
                end
            end
        end
    end

    // tracker flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit         <= 1'b0;
            r_found       <= 1'b0;
            r_found_empty <= 1'b0;
        end else begin
            r_hit         <= n_hit;
            r_found       <= n_found;
            r_found_empty <= n_found_empty;
        end
    end

    // tracker payload
    always_ff @(posedge i_clk) begin
        r_hit_slot <= n_hit_slot;
        r_best     <= n_best;
        r_best_age <= n_best_age;
    end

    assign o_res.hit      = r_hit;
    assign o_res.hit_slot = r_hit_slot;
    assign o_res.found    = r_found;
    assign o_res.best     = r_best;

endmodule
`default_nettype wire

/* hw/rtl/locked_lru_frame_cache_top.sv */
// locked lru frame cache
// requests arrive on i_req (action, frame_number, slot) and each one gives
// exactly one response on o_rsp (status, result_slot), in request order.
// a get reads the tag store one slot per cycle through its single read port,
// tracking the matching slot and a victim as data returns: the lowest empty
// unpinned slot, else the oldest unpinned one. a get responds once this
// slot-serial scan has finished; unlock, unlock all and purge need no scan.
// one request is in flight at a time: a new request is taken only after the
// previous one has moved its response into the output register.
// the response sits in an output register: a new request is taken while it
// waits, but that request only commits its state change when the output
// register is free, so a stalled receiver holds the cache state as is.
// reset (synchronous, i_rst_n low) clears all valid bits, pin counts and the
// use counter; tag and time entries need no clearing, so requests are taken
// in the first cycle after reset.
`default_nettype none
`include "assert_macros.svh"
module locked_lru_frame_cache_top import lfc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    lfc_req_if.sink   i_req,
    lfc_rsp_if.source o_rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [1:0]     r_act;
    t_tag           r_frame;
    logic [2:0]     r_slot;
    t_cnt           r_rd_idx, n_rd_idx;
    logic           r_rd_vld;
    t_idx           r_rd_slot;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    t_pin           r_pin [NUM_SLOTS];
    t_pin           n_pin [NUM_SLOTS];
    t_time          r_use_cnt;
    logic           r_out_valid;
    logic [2:0]     r_out_status;
    logic [2:0]     r_out_rs;

    logic           in_fire;
    logic           rd_en;
    logic           fin_fire;
    logic           fin_commit;
    logic [2:0]     fin_status;
    logic [2:0]     fin_rs;
    t_idx           fin_idx;
    t_idx           unl_idx;
    logic           unl_ok;
    logic [NUM_SLOTS-1:0] pin_nz;
    t_entry         rd_data;
    t_entry         wr_data;
    t_scan_ctl      scan_ctl;
    t_scan_res      scan_res;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign rd_en       = (r_state == S_SCAN) && (r_rd_idx < t_cnt'(NUM_SLOTS));
    assign fin_fire    = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_rd_idx = r_rd_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_rd_idx = '0;
                    n_state  = (i_req.action == ACT_GET) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + t_cnt'(1);
                end else if (r_rd_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= rd_en;
        end
    end

    // request capture and read slot tracking
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act   <= i_req.action;
            r_frame <= i_req.frame_number;
            r_slot  <= i_req.slot;
        end
        r_rd_slot <= r_rd_idx[IDX_W-1:0];
    end

    // tag and time store
    assign wr_data.tag      = r_frame;
    assign wr_data.last_use = r_use_cnt;

    lfc_tag_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (fin_fire && fin_commit),
        .i_wr_addr (fin_idx),
        .i_wr_data (wr_data)
    );

    // scan tracker
    assign scan_ctl.start       = in_fire;
    assign scan_ctl.rd_vld      = r_rd_vld;
    assign scan_ctl.slot        = r_rd_slot;
    assign scan_ctl.slot_valid  = r_valid[r_rd_slot];
    assign scan_ctl.slot_pinned = (r_pin[r_rd_slot] != '0);

    lfc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_frame   (r_frame),
        .i_use_cnt (r_use_cnt),
        .i_entry   (rd_data),
        .o_res     (scan_res)
    );

    // outcome of the request
    assign unl_idx = slot_to_idx(r_slot);
    assign unl_ok  = slot_in_range(r_slot);

    always_comb begin
        fin_commit = 1'b0;
        fin_status = ST_DONE;
        fin_rs     = 3'd0;
        fin_idx    = scan_res.best;
        case (r_act)
            ACT_GET: begin
                if (scan_res.hit) begin
                    fin_commit = 1'b1;
                    fin_status = ST_HIT;
                    fin_idx    = scan_res.hit_slot;
                    fin_rs     = idx_to_rs(scan_res.hit_slot);
                end else if (scan_res.found) begin
                    fin_commit = 1'b1;
                    fin_status = ST_MISS;
                    fin_rs     = idx_to_rs(scan_res.best);
                end else begin
                    fin_status = ST_ALL_PINNED;
                end
            end
            ACT_UNLOCK: begin
                fin_rs = r_slot;
                if (unl_ok && r_pin[unl_idx] == '0) begin
                    fin_status = ST_UNDERFLOW;
                end
            end
            default: fin_status = ST_DONE;
        endcase
    end

    // valid bits and pin counts
    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_pin[i] = r_pin[i];
            if (fin_fire) begin
                if (r_act == ACT_GET && fin_commit && fin_idx == t_idx'(i)) begin
                    n_valid[i] = 1'b1;
                    if (r_pin[i] != PIN_MAX) begin
                        n_pin[i] = r_pin[i] + t_pin'(1);
                    end
                end
                if (r_act == ACT_UNLOCK && unl_ok && unl_idx == t_idx'(i)
                        && r_pin[i] != '0) begin
                    n_pin[i] = r_pin[i] - t_pin'(1);
                end
                if (r_act == ACT_UNLOCK_ALL || r_act == ACT_PURGE) begin
                    n_pin[i] = '0;
                end
                if (r_act == ACT_PURGE) begin
                    n_valid[i] = 1'b0;
                end
            end
            pin_nz[i] = (r_pin[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_use_cnt <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_pin[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_pin[i] <= n_pin[i];
            end
            if (fin_fire && fin_commit) begin
                r_use_cnt <= r_use_cnt + t_time'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_out_status <= fin_status;
            r_out_rs     <= fin_rs;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.result_slot = r_out_rs;

    // a transfer in always starts work
    `ASSERT_PROP(a_busy_after_req, i_clk, i_rst_n, in_fire |=> r_state != S_IDLE)
    // the read pipeline is drained before the result is committed
    `ASSERT_NEVER(a_scan_drained, i_clk, i_rst_n, r_state == S_FINISH && r_rd_vld)
    // the use counter moves only when a request commits
    `ASSERT_PROP(a_cnt_hold, i_clk, i_rst_n, !fin_fire |=> $stable(r_use_cnt))
    // a pinned slot is always a valid slot
    `ASSERT_NEVER(a_pin_valid, i_clk, i_rst_n, (pin_nz & ~r_valid) != '0)

endmodule
`default_nettype wire

/* dv/locked_lru_frame_cache_top_test.sv */
`timescale 1ns / 100ps
`default_nettype none
module locked_lru_frame_cache_top_test;
    import lfc_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int SAT_GETS    = 258;
    localparam int POOL_SIZE   = 16;

    // expected response of one request
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot;
    } t_cache_reply;

    // ready patterns of the response side
    typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    // shadow copy of the tag store; predicts and checks responses in order
    class frame_cache_shadow;
        t_tag         tags[NUM_SLOTS];
        bit           used[NUM_SLOTS];
        t_pin         pins[NUM_SLOTS];
        t_time        stamps[NUM_SLOTS];
        t_time        use_clock;
        t_cache_reply pending_replies[$];
        int           failures;

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                tags[i]   = '0;
                used[i]   = 1'b0;
                pins[i]   = '0;
                stamps[i] = '0;
            end
            use_clock = '0;
            failures  = 0;
        endfunction

        // pin with saturation and stamp with the use clock
        function void pin_slot(int s);
            if (pins[s] != PIN_MAX)
                pins[s] = pins[s] + t_pin'(1);
            stamps[s] = use_clock;
            use_clock = use_clock + t_time'(1);
        endfunction

        function void note_request(logic [1:0] action, t_tag frame, logic [2:0] slot);
            t_cache_reply reply;
            int           i;
            int           victim;
            bit           have_victim;
            bit           have_empty;
            t_time        oldest;
            t_time        age;
            reply.status = ST_DONE;
            reply.slot   = '0;
            victim       = -1;
            have_victim  = 1'b0;
            have_empty   = 1'b0;
            oldest       = '0;
            case (action)
                ACT_GET: begin
                    // tag search over valid slots
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (victim < 0 && used[i] && tags[i] == frame)
                            victim = i;
                    if (victim >= 0) begin
                        pin_slot(victim);
                        reply.status = ST_HIT;
                        reply.slot   = 3'(victim);
                    end else begin
                        // lowest empty unpinned slot, else the oldest unpinned one
                        for (i = 0; i < NUM_SLOTS; i++) begin
                            if (pins[i] == '0) begin
                                if (!used[i]) begin
                                    if (!have_empty) begin
                                        have_empty  = 1'b1;
                                        have_victim = 1'b1;
                                        victim      = i;
                                    end
                                end else if (!have_empty) begin
                                    age = use_clock - stamps[i];
                                    if (!have_victim || age > oldest) begin
                                        have_victim = 1'b1;
                                        victim      = i;
                                        oldest      = age;
                                    end
                                end
                            end
                        end
                        if (!have_victim) begin
                            reply.status = ST_ALL_PINNED;
                        end else begin
                            tags[victim] = frame;
                            used[victim] = 1'b1;
                            pin_slot(victim);
                            reply.status = ST_MISS;
                            reply.slot   = 3'(victim);
                        end
                    end
                end
                ACT_UNLOCK: begin
                    reply.slot = slot;
                    if (int'(slot) < NUM_SLOTS) begin
                        if (pins[slot] == '0)
                            reply.status = ST_UNDERFLOW;
                        else
                            pins[slot] = pins[slot] - t_pin'(1);
                    end
                end
                ACT_UNLOCK_ALL: begin
                    for (i = 0; i < NUM_SLOTS; i++)
                        pins[i] = '0;
                end
                default: begin
                    for (i = 0; i < NUM_SLOTS; i++) begin
                        pins[i] = '0;
                        used[i] = 1'b0;
                    end
                end
            endcase
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [2:0] status, logic [2:0] slot);
            t_cache_reply want;
            if (pending_replies.size() == 0) begin
                $display("%0t: response with nothing outstanding: status %0d slot %0d",
                         $time, status, slot);
                failures++;
            end else begin
                want = pending_replies.pop_front();
                if (want.status !== status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, status);
                    failures++;
                end
                if (want.slot !== slot) begin
                    $display("%0t: result_slot mismatch: expected %0d actual %0d",
                             $time, want.slot, slot);
                    failures++;
                end
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lfc_req_if req_bus ();
    lfc_rsp_if rsp_bus ();

    locked_lru_frame_cache_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    frame_cache_shadow shadow;
    t_tag              frame_pool[POOL_SIZE];
    int                requests_sent;
    int                cycle_count;
    bit                hold_pending;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // response ready pattern, with one long hold-off on request
    initial begin
        t_rx_mode rx_mode;
        int       span;
        int       hold_left;
        int       period;
        int       tick;
        rsp_bus.ready = 1'b0;
        rx_mode       = RX_ALWAYS;
        span          = 0;
        hold_left     = 0;
        period        = 2;
        tick          = 0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(3));
                    span    = $urandom_range(20, 200);
                    period  = $urandom_range(2, 5);
                end
                span--;
                tick++;
                case (rx_mode)
                    RX_ALWAYS:   rsp_bus.ready <= 1'b1;
                    RX_COIN:     rsp_bus.ready <= 1'($urandom_range(1));
                    RX_PERIODIC: rsp_bus.ready <= (tick % period) != 0;
                    default:     rsp_bus.ready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    // check every response transfer
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            shadow.check_reply(rsp_bus.status, rsp_bus.result_slot);
    end

    // one request transfer, held until accepted
    task automatic send_request(input logic [1:0] action, input t_tag frame,
                                input logic [2:0] slot);
        @(negedge i_clk);
        req_bus.valid        <= 1'b1;
        req_bus.action       <= action;
        req_bus.frame_number <= frame;
        req_bus.slot         <= slot;
        do @(posedge i_clk); while (!req_bus.ready);
        shadow.note_request(action, frame, slot);
        requests_sent++;
    endtask

    // idle the request side, scrambling the payload
    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            req_bus.valid        <= 1'b0;
            req_bus.action       <= 2'($urandom_range(3));
            req_bus.frame_number <= $urandom;
            req_bus.slot         <= 3'($urandom_range(7));
        end
    endtask

    task automatic wait_for_drain();
        pause_sender(1);
        while (shadow.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // random request, frames mostly from a small pool so hits occur
    task automatic pick_request(output logic [1:0] action, output t_tag frame,
                                output logic [2:0] slot);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            action = ACT_GET;
        else if (roll < 88)
            action = ACT_UNLOCK;
        else if (roll < 95)
            action = ACT_UNLOCK_ALL;
        else
            action = ACT_PURGE;
        if ($urandom_range(15) == 0)
            frame_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
        if ($urandom_range(4) == 0)
            frame = $urandom;
        else
            frame = frame_pool[$urandom_range(POOL_SIZE - 1)];
        slot = 3'($urandom_range(7));
    endtask

    initial begin
        logic [1:0] action;
        t_tag       frame;
        t_tag       sat_frame;
        logic [2:0] slot;
        int         burst_len;
        int         roll;
        bit         saturation_done;
        bit         hold_done;

        shadow               = new();
        requests_sent        = 0;
        hold_pending         = 1'b0;
        saturation_done      = 1'b0;
        hold_done            = 1'b0;
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.action       = ACT_GET;
        req_bus.frame_number = '0;
        req_bus.slot         = '0;

        frame_pool[0] = 32'h0000_0000;
        frame_pool[1] = 32'hFFFF_FFFF;
        frame_pool[2] = 32'hFFFF_0000;
        frame_pool[3] = 32'h0000_0FFF;
        frame_pool[4] = 32'hAAAA_AAAA;
        frame_pool[5] = 32'h5555_5555;
        for (int i = 6; i < POOL_SIZE; i++)
            frame_pool[i] = $urandom;

        // reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot, then a hit and an all-pinned miss
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(ACT_GET, frame_pool[i], 3'd0);
        send_request(ACT_GET, frame_pool[1], 3'd7);
        send_request(ACT_GET, frame_pool[8], 3'd0);
        // unlock down to zero, then underflow
        send_request(ACT_UNLOCK, 32'hFFFF_FFFF, 3'd3);
        send_request(ACT_UNLOCK, 32'h0, 3'd3);
        send_request(ACT_UNLOCK, 32'h0, 3'd1);
        send_request(ACT_UNLOCK, 32'h0, 3'd1);
        // victim by age among unpinned slots
        send_request(ACT_GET, frame_pool[9], 3'd0);
        send_request(ACT_UNLOCK_ALL, 32'h0, 3'd0);
        send_request(ACT_GET, frame_pool[10], 3'd0);
        // purge keeps the use clock, empty slots win
        send_request(ACT_PURGE, 32'hFFFF_FFFF, 3'd7);
        send_request(ACT_GET, frame_pool[2], 3'd0);
        send_request(ACT_UNLOCK, 32'h0, 3'd7);
        send_request(ACT_UNLOCK, 32'h0, 3'd0);
        send_request(ACT_GET, frame_pool[2], 3'd0);
        send_request(ACT_GET, frame_pool[3], 3'd0);
        wait_for_drain();

        // random traffic in bursts
        while (requests_sent < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (!saturation_done && requests_sent > 300) begin
                // pin one slot past its maximum count, then step it down
                saturation_done = 1'b1;
                sat_frame = $urandom;
                send_request(ACT_PURGE, $urandom, 3'($urandom_range(7)));
                repeat (SAT_GETS)
                    send_request(ACT_GET, sat_frame, 3'($urandom_range(7)));
                send_request(ACT_UNLOCK, $urandom, 3'd0);
                send_request(ACT_UNLOCK, $urandom, 3'd0);
                send_request(ACT_GET, sat_frame, 3'd0);
                send_request(ACT_UNLOCK_ALL, $urandom, 3'($urandom_range(7)));
            end else if (!hold_done && requests_sent > 700) begin
                // receiver holds off while requests keep coming
                hold_done    = 1'b1;
                hold_pending = 1'b1;
                repeat (16) begin
                    pick_request(action, frame, slot);
                    send_request(action, frame, slot);
                end
            end else if (roll < 4) begin
                wait_for_drain();
                pause_sender($urandom_range(0, 5));
            end else begin
                burst_len = $urandom_range(1, 16);
                repeat (burst_len) begin
                    pick_request(action, frame, slot);
                    send_request(action, frame, slot);
                end
                if ($urandom_range(3) != 0)
                    pause_sender($urandom_range(1, 10));
            end
        end

        // drain and let any stray response show up
        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (shadow.failures == 0 && shadow.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
